>>> hdl/rrdt_pkg.sv
// shared types, constants and the sine table generator for the reactance relay
package rrdt_pkg;

  localparam int unsigned PHASES_DEF           = 3;
  localparam int unsigned MAG_BITS_DEF         = 16;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;

  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned PICKUP_W   = 20;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned COUNT_W    = 17;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned PHASE_W    = 2;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned SINE_W     = 16;
  localparam int unsigned SINE_MAG_W = 15;
  localparam int unsigned PICKUP_SHIFT = 7;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
  localparam logic [PICKUP_W-1:0] PICKUP_RESET = 20'd1048575;
  localparam logic [DELAY_W-1:0]  DELAY_RESET  = 16'd1000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [63:0] ONE_Q30 = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PICKUP_REACTANCE = 2'd0,
    CFG_DELAY_PERIODS    = 2'd1
  } cfg_index_e;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic               picked_up;
    logic               phase_trip;
    logic               any_trip;
  } rrdt_result_t;

  // sine magnitude in q0.15 of a q30 angle between 0 and pi/2, taylor series in q30
  function automatic logic [SINE_MAG_W-1:0] sine_mag(input logic [63:0] theta);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] prod;
    logic signed [63:0] sum;
    logic signed [63:0] s;
    logic signed [63:0] v;
    x2   = (theta * theta) >> 30;
    term = theta;
    sum  = '0;
    for (int n = 0; n < 6; n++) begin
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
      prod = (term * x2) >> 30;
      case (n)
        0: term = prod / 64'd6;
        1: term = prod / 64'd20;
        2: term = prod / 64'd42;
        3: term = prod / 64'd72;
        4: term = prod / 64'd110;
        default: term = prod / 64'd156;
      endcase
    end
    s = sum;
    if (s < 0) begin
      s = '0;
    end
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    v = (s * 64'sd32767 + (ONE_Q30 >>> 1)) >>> 30;
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end
    return v[SINE_MAG_W-1:0];
  endfunction

endpackage

>>> hdl/reactance_relay_definite_time_core.sv
// top level of the three phase definite time reactance relay
//
//   port group  dir  carries
//   s_axis      in   one phasor sample of one phase a transaction
//   m_axis      out  one pickup / trip result per sample
//   cfg         in   register writes, no read-back
//
// one sample a cycle while the result side is not stalled: input register, table lookup plus two
// multipliers and a compare, result register
// the per phase counter update sits in the same cycle, so samples of one phase follow freely
// reset clears the counters, trip flags and the valid flags of both registers and loads the default thresholds
// a stalled result holds its register; the input register still takes a sample while it is
// empty, or otherwise if the result register is free or being taken in that cycle
module reactance_relay_definite_time_core #(
  parameter int unsigned PHASES           = rrdt_pkg::PHASES_DEF,
  parameter int unsigned MAG_BITS         = rrdt_pkg::MAG_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = rrdt_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // voltage_magnitude, voltage_angle, current_magnitude, current_angle
  input  logic [rrdt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // phase
  input  logic [rrdt_pkg::PHASE_W-1:0]       s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // picked_up, phase_trip, any_trip, zero fill
  output logic [rrdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // phase_out
  output logic [rrdt_pkg::PHASE_W-1:0]       m_axis_tuser,
  input  logic                               cfg_we_i,
  input  logic [rrdt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rrdt_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  logic [rrdt_pkg::PICKUP_W-1:0] pickup_q;
  logic [rrdt_pkg::DELAY_W-1:0]  delay_q;

  logic                          s1_valid_q, s1_valid_d;
  logic [rrdt_pkg::PHASE_W-1:0]  s1_phase_q;
  logic [rrdt_pkg::FIELD_W-1:0]  s1_vmag_q, s1_vang_q, s1_imag_q, s1_iang_q;

  logic                          out_valid_q, out_valid_d;
  rrdt_pkg::rrdt_result_t        out_res_q;

  logic                          out_adv;
  logic                          s1_fire;
  logic                          in_fire;
  logic [rrdt_pkg::FIELD_W-1:0]  diff;
  logic                          picked_up;
  rrdt_pkg::rrdt_result_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pickup_q <= rrdt_pkg::PICKUP_RESET;
      delay_q  <= rrdt_pkg::DELAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rrdt_pkg::CFG_PICKUP_REACTANCE: pickup_q <= cfg_wdata_i[rrdt_pkg::PICKUP_W-1:0];
        rrdt_pkg::CFG_DELAY_PERIODS:    delay_q  <= cfg_wdata_i[rrdt_pkg::DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s1_fire       = s1_valid_q && out_adv;
  assign s_axis_tready = !s1_valid_q || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = out_adv ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_phase_q <= s_axis_tuser;
      s1_vmag_q  <= s_axis_tdata[15:0];
      s1_vang_q  <= s_axis_tdata[31:16];
      s1_imag_q  <= s_axis_tdata[47:32];
      s1_iang_q  <= s_axis_tdata[63:48];
    end
    if (s1_fire) begin
      out_res_q <= res;
    end
  end

  assign diff = s1_vang_q - s1_iang_q;

  rrdt_pickup #(
    .MAG_BITS        (MAG_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_pickup (
    .vmag_i     (s1_vmag_q),
    .imag_i     (s1_imag_q),
    .diff_i     (diff),
    .pickup_i   (pickup_q),
    .picked_up_o(picked_up)
  );

  rrdt_delay #(
    .PHASES(PHASES)
  ) u_delay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .update_i   (s1_fire),
    .phase_i    (s1_phase_q),
    .picked_up_i(picked_up),
    .delay_i    (delay_q),
    .res_o      (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_res_q.phase;
  assign m_axis_tdata  = {5'b0, out_res_q.any_trip, out_res_q.phase_trip, out_res_q.picked_up};

  a_trip_needs_pickup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("phase trip without pickup");

  a_trip_in_any: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
    else $error("phase trip missing from any trip");

  a_stall_only_on_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output free");

  a_sample_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> m_axis_tvalid)
    else $error("sample lost between stages");

endmodule

>>> hdl/rrdt_sine.sv
// sine of the phasor angle difference from a quarter wave table
module rrdt_sine #(
  parameter int unsigned SINE_TABLE_DEPTH = rrdt_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic [rrdt_pkg::FIELD_W-1:0]      diff_i,
  output logic signed [rrdt_pkg::SINE_W-1:0] sine_o
);

  // depth is taken as a multiple of four so the quarter wave points fall on the table
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned M_W    = IDX_W + 2;
  localparam int unsigned QN     = SINE_TABLE_DEPTH / 4 + 1;
  localparam int unsigned LUT_W  = $clog2(QN);
  localparam logic [M_W-1:0] D1 = M_W'(SINE_TABLE_DEPTH);
  localparam logic [M_W-1:0] D2 = M_W'(2 * SINE_TABLE_DEPTH);
  localparam logic [M_W-1:0] D3 = M_W'(3 * SINE_TABLE_DEPTH);

  logic [rrdt_pkg::SINE_MAG_W-1:0] lut [QN];

  for (genvar g = 0; g < QN; g++) begin : g_lut
    localparam logic [63:0] Theta =
      (64'(g) * 64'd4 * rrdt_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    assign lut[g] = rrdt_pkg::sine_mag(Theta);
  end

  logic [31:0]      scaled;
  logic [IDX_W-1:0] idx;
  logic [M_W-1:0]   m;
  logic [1:0]       quad;
  logic [M_W-1:0]   base;
  logic [M_W-1:0]   r;
  logic [M_W-1:0]   a;
  logic [LUT_W-1:0] lut_idx;
  logic [rrdt_pkg::SINE_MAG_W-1:0] mag;
  logic signed [rrdt_pkg::SINE_W-1:0] mag_s;

  assign scaled = 32'(diff_i) * 32'(SINE_TABLE_DEPTH);
  assign idx    = IDX_W'(scaled >> 16);
  assign m      = {idx, 2'b00};

  always_comb begin
    if (m >= D3) begin
      quad = 2'd3;
      base = D3;
    end else if (m >= D2) begin
      quad = 2'd2;
      base = D2;
    end else if (m >= D1) begin
      quad = 2'd1;
      base = D1;
    end else begin
      quad = 2'd0;
      base = '0;
    end
  end

  assign r       = m - base;
  assign a       = quad[0] ? (D1 - r) : r;
  assign lut_idx = LUT_W'(a >> 2);
  assign mag     = lut[lut_idx];
  assign mag_s   = $signed({1'b0, mag});
  assign sine_o  = quad[1] ? -mag_s : mag_s;

endmodule

>>> hdl/rrdt_pickup.sv
// reactance pickup test without division
module rrdt_pickup #(
  parameter int unsigned MAG_BITS         = rrdt_pkg::MAG_BITS_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = rrdt_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic [rrdt_pkg::FIELD_W-1:0]  vmag_i,
  input  logic [rrdt_pkg::FIELD_W-1:0]  imag_i,
  input  logic [rrdt_pkg::FIELD_W-1:0]  diff_i,
  input  logic [rrdt_pkg::PICKUP_W-1:0] pickup_i,
  output logic                          picked_up_o
);

  localparam int unsigned MAG_W = (MAG_BITS < rrdt_pkg::FIELD_W) ? MAG_BITS : rrdt_pkg::FIELD_W;
  localparam int unsigned LHS_W = MAG_W + 1 + rrdt_pkg::SINE_W;
  localparam int unsigned RHS_W = rrdt_pkg::PICKUP_W + MAG_W + rrdt_pkg::PICKUP_SHIFT;

  logic signed [rrdt_pkg::SINE_W-1:0] sine;
  logic [MAG_W-1:0]                   vm;
  logic [MAG_W-1:0]                   im;
  logic signed [LHS_W-1:0]            lhs;
  logic [RHS_W-1:0]                   rhs;

  rrdt_sine #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_sine (
    .diff_i(diff_i),
    .sine_o(sine)
  );

  assign vm  = vmag_i[MAG_W-1:0];
  assign im  = imag_i[MAG_W-1:0];
  assign lhs = $signed({1'b0, vm}) * sine;
  assign rhs = RHS_W'(RHS_W'(pickup_i) * RHS_W'(im)) << rrdt_pkg::PICKUP_SHIFT;

  assign picked_up_o = (im != '0) && !lhs[LHS_W-1] &&
                       (RHS_W'(lhs[LHS_W-2:0]) > rhs);

endmodule

>>> hdl/rrdt_delay.sv
// per phase pickup counters and definite time trip flags
module rrdt_delay #(
  parameter int unsigned PHASES = rrdt_pkg::PHASES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           update_i,
  input  logic [rrdt_pkg::PHASE_W-1:0]   phase_i,
  input  logic                           picked_up_i,
  input  logic [rrdt_pkg::DELAY_W-1:0]   delay_i,
  output rrdt_pkg::rrdt_result_t         res_o
);

  logic [rrdt_pkg::COUNT_W-1:0] count_q [PHASES];
  logic [PHASES-1:0]            trip_q;

  logic [PHASES-1:0]            hit;
  logic [rrdt_pkg::COUNT_W-1:0] count_sel;
  logic [rrdt_pkg::COUNT_W-1:0] count_inc;
  logic [rrdt_pkg::COUNT_W-1:0] count_d;
  logic                         trip_d;
  logic                         any_d;

  always_comb begin
    count_sel = '0;
    for (int p = 0; p < PHASES; p++) begin
      hit[p] = (phase_i == rrdt_pkg::PHASE_W'(p));
      if (hit[p]) begin
        count_sel = count_q[p];
      end
    end
  end

  assign count_inc = (count_sel == rrdt_pkg::COUNT_MAX) ? count_sel : count_sel + 1'b1;
  assign count_d   = picked_up_i ? count_inc : '0;
  assign trip_d    = picked_up_i && (count_inc > {1'b0, delay_i});

  always_comb begin
    any_d = 1'b0;
    for (int p = 0; p < PHASES; p++) begin
      any_d = any_d | (hit[p] ? trip_d : trip_q[p]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < PHASES; p++) begin
        count_q[p] <= '0;
      end
      trip_q <= '0;
    end else if (update_i) begin
      for (int p = 0; p < PHASES; p++) begin
        if (hit[p]) begin
          count_q[p] <= count_d;
          trip_q[p]  <= trip_d;
        end
      end
    end
  end

  assign res_o.phase      = phase_i;
  assign res_o.picked_up  = (|hit) && picked_up_i;
  assign res_o.phase_trip = (|hit) && trip_d;
  assign res_o.any_trip   = any_d;

endmodule

>>> dv/tb_reactance_relay_definite_time_core.sv
// self-checking testbench of the three phase definite time reactance relay core
module tb_reactance_relay_definite_time_core;
  import rrdt_pkg::*;

  localparam int unsigned PHASE_COUNT = 3;
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint UNITY_Q30 = 64'sd1073741824;
  localparam logic [COUNT_W-1:0] COUNT_CEIL = 17'd131071;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_BLOCKS = 5;
  localparam int BLOCK_LEN = 240;
  localparam int SOAK_LEN = 80;
  localparam int CYCLE_LIMIT = 700000;

  typedef struct packed {
    logic [FIELD_W-1:0] i_ang;
    logic [FIELD_W-1:0] i_mag;
    logic [FIELD_W-1:0] v_ang;
    logic [FIELD_W-1:0] v_mag;
  } phasor_set_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e kind;
    logic [PHASE_W-1:0] ph;
    phasor_set_t smp;
    logic has_exp;
    rrdt_result_t exp_res;
    logic [CFG_IDX_W-1:0] widx;
    logic [CFG_DATA_W-1:0] wval;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic [PHASE_W-1:0] in_phase = '0;
  phasor_set_t in_data = '0;
  logic in_typed = 1'b0;
  rrdt_result_t in_want = '0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic s_axis_tready;
  logic m_axis_tvalid;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [PHASE_W-1:0] m_axis_tuser;

  // predictor state
  int sine_q15 [TABLE_DEPTH];
  logic [PICKUP_W-1:0] pickup_thr = 20'hFFFFF;
  logic [DELAY_W-1:0] delay_thr = 16'd1000;
  logic [COUNT_W-1:0] run_len [PHASE_COUNT] = '{default: '0};
  logic [PHASE_COUNT-1:0] trip_flag = '0;

  rrdt_result_t pending_results [$];
  int err_count = 0;
  int cycle_count = 0;
  bit idling = 1'b1;
  int rx_hold_left = 0;
  int rx_gap_left = 0;

  reactance_relay_definite_time_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (in_data),
    .s_axis_tuser  (in_phase),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_idx),
    .cfg_wdata_i   (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // q1.15 sine per table entry, quadrant folding and taylor series in q30
  initial begin : sine_build
    longint unsigned quad, rem, a, theta, x2, term;
    longint acc, v;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      quad = (4 * k) / TABLE_DEPTH;
      rem = (4 * k) % TABLE_DEPTH;
      a = quad[0] ? TABLE_DEPTH - rem : rem;
      theta = a * QUARTER_TURN_Q30 / TABLE_DEPTH;
      x2 = (theta * theta) >> 30;
      term = theta;
      acc = 0;
      for (int n = 0; n < 6; n++) begin
        acc = (n % 2) ? acc - longint'(term) : acc + longint'(term);
        term = ((term * x2) >> 30) / ((2 * n + 2) * (2 * n + 3));
      end
      if (acc < 0) acc = 0;
      if (acc > UNITY_Q30) acc = UNITY_Q30;
      v = (acc * 32767 + UNITY_Q30 / 2) >>> 30;
      if (v > 32767) v = 32767;
      sine_q15[k] = (quad >= 2) ? -int'(v) : int'(v);
    end
  end

  function automatic rrdt_result_t relay_update(input logic [PHASE_W-1:0] ph,
                                                input phasor_set_t s);
    rrdt_result_t r;
    logic [FIELD_W-1:0] diff;
    longint lhs, rhs;
    logic hit;
    r = '0;
    r.phase = ph;
    diff = s.v_ang - s.i_ang;
    if (ph < PHASE_COUNT) begin
      lhs = longint'(s.v_mag) * longint'(sine_q15[diff[15:6]]);
      rhs = longint'(pickup_thr) * longint'(s.i_mag) * 128;
      hit = (s.i_mag != 0) && (lhs > rhs);
      if (hit) begin
        if (run_len[ph] != COUNT_CEIL) run_len[ph] = run_len[ph] + 1'b1;
        trip_flag[ph] = run_len[ph] > delay_thr;
      end else begin
        run_len[ph] = '0;
        trip_flag[ph] = 1'b0;
      end
      r.picked_up = hit;
      r.phase_trip = trip_flag[ph];
    end
    r.any_trip = |trip_flag;
    return r;
  endfunction

  // scoreboard: results first, then newly accepted samples and register writes
  always @(posedge clk_i) begin
    rrdt_result_t want;
    logic [OUT_TDATA_W-1:0] want_bits;
    if (rst_n) begin
      if (m_axis_tvalid && out_ready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("unexpected result: phase %0d data %b", m_axis_tuser, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          want_bits = {{(OUT_TDATA_W-3){1'b0}}, want.any_trip, want.phase_trip,
                       want.picked_up};
          if (m_axis_tuser != want.phase || m_axis_tdata != want_bits) begin
            err_count++;
            if (err_count <= 10)
              $display("mismatch: expected phase %0d data %b, got phase %0d data %b",
                       want.phase, want_bits, m_axis_tuser, m_axis_tdata);
          end
        end
      end
      if (in_valid && s_axis_tready) begin
        want = relay_update(in_phase, in_data);
        pending_results.push_back(in_typed ? in_want : want);
      end
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PICKUP_REACTANCE: pickup_thr = cfg_data;
          CFG_DELAY_PERIODS:    delay_thr = cfg_data[DELAY_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // result side: random stall bursts plus one long hold-off on request
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (idling && $urandom_range(0, 5) == 0) rx_gap_left = $urandom_range(1, 7);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_reactance_relay_definite_time_core: errors");
      $finish;
    end
  end

  task automatic send_sample(input logic [PHASE_W-1:0] ph, input phasor_set_t s,
                             input logic typed, input rrdt_result_t want);
    int gap;
    @(negedge clk_i);
    if (idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_phase <= ph;
    in_data <= s;
    in_typed <= typed;
    in_want <= want;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t sample_row(input logic [PHASE_W-1:0] ph,
                                           input logic [FIELD_W-1:0] vm, va, im, ia);
    plan_row_t r;
    r = '{kind: ROW_SAMPLE, ph: ph, smp: '0, has_exp: 1'b0, exp_res: '0, widx: '0,
          wval: '0};
    r.smp = '{i_ang: ia, i_mag: im, v_ang: va, v_mag: vm};
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [PHASE_W-1:0] ph,
                                          input logic [FIELD_W-1:0] vm, va, im, ia,
                                          input logic [2:0] any_trip_pu);
    plan_row_t r;
    r = sample_row(ph, vm, va, im, ia);
    r.has_exp = 1'b1;
    r.exp_res.phase = ph;
    {r.exp_res.any_trip, r.exp_res.phase_trip, r.exp_res.picked_up} = any_trip_pu;
    return r;
  endfunction

  function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '{kind: ROW_WRITE, ph: '0, smp: '0, has_exp: 1'b0, exp_res: '0, widx: idx,
          wval: val};
    return r;
  endfunction

  initial begin
    plan_row_t plan [$];
    phasor_set_t s;
    logic [PHASE_W-1:0] ph;
    logic [FIELD_W-1:0] diff;
    logic [PICKUP_W-1:0] pick;
    logic [DELAY_W-1:0] hold;
    longint vm_calc;
    int r, fault_ph;

    // reset defaults: zero samples, zero current, out of range phase
    plan.push_back(typed_row(2'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'b000));
    plan.push_back(typed_row(2'd1, 16'hFFFF, 16'h4000, 16'h0000, 16'h0000, 3'b000));
    plan.push_back(sample_row(2'd2, 16'hFFFF, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(typed_row(2'd3, 16'hFFFF, 16'h4000, 16'h0001, 16'h0000, 3'b000));
    plan.push_back(sample_row(2'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h7FFF));
    plan.push_back(sample_row(2'd0, 16'hFFFF, 16'h7FFF, 16'h0001, 16'h8000));
    plan.push_back(sample_row(2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    // writes to unmapped indexes must leave both thresholds alone
    plan.push_back(write_row(CFG_SPARE_LO, 20'h00000));
    plan.push_back(write_row(CFG_SPARE_HI, 20'h00000));
    plan.push_back(sample_row(2'd2, 16'hFFFF, 16'h4000, 16'h0001, 16'h0000));
    // zero pickup and zero delay
    plan.push_back(write_row(CFG_PICKUP_REACTANCE, 20'h00000));
    plan.push_back(write_row(CFG_DELAY_PERIODS, 20'h00000));
    plan.push_back(sample_row(2'd0, 16'h0001, 16'h4000, 16'hFFFF, 16'h0000));
    plan.push_back(sample_row(2'd1, 16'h0000, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd2, 16'hFFFF, 16'hC000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd0, 16'hFFFF, 16'h0000, 16'h0001, 16'h0000));
    // exact equality does not pick up, then a short delay runs out
    plan.push_back(write_row(CFG_PICKUP_REACTANCE, 20'd32767));
    plan.push_back(write_row(CFG_DELAY_PERIODS, 20'd2));
    plan.push_back(sample_row(2'd1, 16'h0080, 16'h4000, 16'h0001, 16'h0000));
    for (int n = 0; n < 3; n++)
      plan.push_back(sample_row(2'd1, 16'h0081, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd3, 16'h0081, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd2, 16'h0081, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd1, 16'h0080, 16'h4000, 16'h0001, 16'h0000));
    plan.push_back(sample_row(2'd2, 16'h0081, 16'h4000, 16'h0001, 16'h0000));

    repeat (10) @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE)
        program_reg(plan[i].widx, plan[i].wval);
      else
        send_sample(plan[i].ph, plan[i].smp, plan[i].has_exp, plan[i].exp_res);
    end

    fault_ph = 0;
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      case (b)
        0: begin
          pick = PICKUP_W'($urandom_range(64, 4096));
          hold = '0;
        end
        1: begin
          pick = '0;
          hold = DELAY_W'($urandom_range(1, 25));
        end
        2: begin
          pick = 20'hFFFFF;
          hold = DELAY_W'($urandom_range(1, 25));
        end
        default: begin
          pick = PICKUP_W'($urandom_range(64, 8192));
          hold = DELAY_W'($urandom_range(1, 25));
        end
      endcase
      idling = (b != 3);
      program_reg(CFG_PICKUP_REACTANCE, pick);
      program_reg(CFG_DELAY_PERIODS, {4'd0, hold});
      for (int n = 0; n < BLOCK_LEN; n++) begin
        if (b == 2 && n == 100) rx_hold_left = 200;
        if ($urandom_range(0, 29) == 0) fault_ph = $urandom_range(0, 2);
        r = $urandom_range(0, 99);
        s.v_ang = FIELD_W'($urandom());
        if (r < 55) begin
          // fault seen forward on one phase
          ph = PHASE_W'(fault_ph);
          s.v_mag = FIELD_W'($urandom_range(30000, 65535));
          s.i_mag = ($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(1, 600))
                                                : FIELD_W'($urandom_range(1, 12));
          diff = FIELD_W'($urandom_range(16'h0800, 16'h7800));
        end else if (r < 85) begin
          // healthy load on the other phases
          ph = PHASE_W'((fault_ph + 1 + $urandom_range(0, 1)) % 3);
          s.v_mag = FIELD_W'($urandom_range(20000, 65535));
          s.i_mag = FIELD_W'($urandom_range(2000, 65535));
          diff = FIELD_W'($urandom_range(0, 16'h1000) - 16'h0800);
        end else if (r < 95) begin
          ph = PHASE_W'($urandom());
          s.v_mag = FIELD_W'($urandom());
          s.i_mag = FIELD_W'($urandom());
          diff = FIELD_W'($urandom());
        end else begin
          // right on the threshold at a quarter turn
          ph = PHASE_W'($urandom_range(0, 3));
          s.i_mag = FIELD_W'($urandom_range(1, 15));
          vm_calc = longint'(pick) * longint'(s.i_mag) * 128 / 32767
                    + longint'($urandom_range(0, 2)) - 1;
          s.v_mag = (vm_calc > 65535) ? 16'hFFFF : (vm_calc < 0) ? 16'h0000
                                                                  : vm_calc[15:0];
          diff = 16'h4000;
        end
        s.i_ang = s.v_ang - diff;
        send_sample(ph, s, 1'b0, '0);
      end
    end

    // unbroken pickup on one phase until the delay runs out
    idling = 1'b0;
    program_reg(CFG_PICKUP_REACTANCE, 20'hFFFFF);
    program_reg(CFG_DELAY_PERIODS, 20'd64);
    for (int n = 0; n < SOAK_LEN; n++) begin
      s.v_mag = FIELD_W'($urandom_range(16'hF000, 16'hFFFF));
      s.v_ang = FIELD_W'($urandom());
      s.i_mag = 16'd1;
      s.i_ang = s.v_ang - 16'h4000;
      send_sample(2'd0, s, 1'b0, '0);
    end
    for (int n = 0; n < 40; n++) begin
      ph = PHASE_W'($urandom());
      s = {$urandom(), $urandom()};
      send_sample(ph, s, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_reactance_relay_definite_time_core: clean");
    end else begin
      $display("tb_reactance_relay_definite_time_core: errors");
    end
    $finish;
  end

endmodule
